// File: sv/xyz_to_lab_converter_unit_macros.svh
// Assertion macros shared by the XYZ to Lab converter RTL.
`ifndef XYZ_TO_LAB_CONVERTER_UNIT_MACROS_SVH
`define XYZ_TO_LAB_CONVERTER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define XYZL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("xyz_to_lab: same-cycle check failed");

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define XYZL_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("xyz_to_lab: next-cycle check failed");

`endif

// File: sv/xyzl_pkg.sv
// Package: widths, constants and types of the XYZ to Lab converter.
`timescale 1ns / 1ps
`default_nettype none
package xyzl_pkg;
	localparam int FRAC_BITS_DEF = 16;

	localparam int IN_W    = 17;
	localparam int WHITE_W = 17;
	localparam int THR_W   = 16;
	localparam int SLOPE_W = 18;
	localparam int CFG_W   = 18;
	localparam int IDX_W   = 3;

	// f values carry 28 fraction bits; outputs carry 8
	localparam int FQ        = 28;
	localparam int OUT_SHIFT = FQ - 8;

	// long division: v * 2^(3*FQ) has IN_W + 3*FQ bits
	localparam int DIV_W = IN_W + 3 * FQ;
	localparam int DEN_W = 32;
	localparam int NUM_W = SLOPE_W + IN_W + 1;

	// cube root: 35 result bits, three radicand bits per step
	localparam int ROOT_STEPS = 35;
	localparam int X_W  = 3 * ROOT_STEPS;
	localparam int Y_W  = ROOT_STEPS;
	localparam int Y2_W = 2 * ROOT_STEPS;
	localparam int B_W  = Y2_W + 2;

	localparam int F_W   = 50;
	localparam int RAW_W = 64;

	localparam logic [14:0] LIN_DEN = 15'd29696;

	localparam int LANE_LAT  = 2 + DIV_W + ROOT_STEPS;
	localparam int MERGE_LAT = 2;
	localparam int PIPE_LAT  = LANE_LAT + MERGE_LAT;

	localparam int LAB_L_MIN = 0;
	localparam int LAB_L_MAX = 40959;
	localparam int LAB_A_MIN = -163840;
	localparam int LAB_A_MAX = 163839;
	localparam int LAB_B_MIN = -65536;
	localparam int LAB_B_MAX = 65535;

	localparam logic [WHITE_W-1:0] WHITE_X_RST = 17'd62289;
	localparam logic [WHITE_W-1:0] WHITE_Y_RST = 17'd65536;
	localparam logic [WHITE_W-1:0] WHITE_Z_RST = 17'd71358;
	localparam logic [THR_W-1:0]   THR_RST     = 16'd580;
	localparam logic [SLOPE_W-1:0] SLOPE_RST   = 18'd231244;

	typedef enum logic [IDX_W-1:0] {
		REG_WHITE_X = 3'd0,
		REG_WHITE_Y = 3'd1,
		REG_WHITE_Z = 3'd2,
		REG_THR     = 3'd3,
		REG_SLOPE   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [WHITE_W-1:0] white;
		logic [THR_W-1:0]   thr;
		logic [SLOPE_W-1:0] slope;
	} lane_cfg_t;
endpackage
`default_nettype wire

// File: sv/xyz_to_lab_converter_unit.sv
// Top level: CIE XYZ to CIELAB converter, three lanes and a merge stage.
// Pipeline: 2 front, 101 divide, 35 cube root and 2 merge stages; a beat reaches
//   the output after passing them all, delayed only while the output is stalled.
// Throughput: one beat per cycle; every stage is a flop, the whole pipe
//   advances together whenever the output register is free or being taken.
// Reset: arst_n clears the valid chain and loads the D65 white defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "xyz_to_lab_converter_unit_macros.svh"
module xyz_to_lab_converter_unit #(
	parameter int FRAC_BITS = xyzl_pkg::FRAC_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// config write port
	input  wire logic                       cfg_wr_en,
	input  wire logic [xyzl_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [xyzl_pkg::CFG_W-1:0] cfg_data,
	// input channel
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [xyzl_pkg::IN_W-1:0]  x_value,
	input  wire logic [xyzl_pkg::IN_W-1:0]  y_value,
	input  wire logic [xyzl_pkg::IN_W-1:0]  z_value,
	// output channel
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [15:0]                     lightness,
	output logic signed [18:0]              green_red,
	output logic signed [16:0]              blue_yellow
);
	import xyzl_pkg::*;

	// ---------------- configuration registers ----------------
	logic [WHITE_W-1:0] white_x_q, white_y_q, white_z_q;
	logic [THR_W-1:0]   thr_q;
	logic [SLOPE_W-1:0] slope_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_x_q <= WHITE_X_RST;
			white_y_q <= WHITE_Y_RST;
			white_z_q <= WHITE_Z_RST;
			thr_q     <= THR_RST;
			slope_q   <= SLOPE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WHITE_X: white_x_q <= cfg_data[WHITE_W-1:0];
				REG_WHITE_Y: white_y_q <= cfg_data[WHITE_W-1:0];
				REG_WHITE_Z: white_z_q <= cfg_data[WHITE_W-1:0];
				REG_THR:     thr_q     <= cfg_data[THR_W-1:0];
				REG_SLOPE:   slope_q   <= cfg_data[SLOPE_W-1:0];
				default: ;   // unmapped index: dropped
			endcase
		end
	end

	// Config must be changed only while idle, which the block does not enforce; lanes read it live at every stage.
	lane_cfg_t cfg_x, cfg_y, cfg_z;
	assign cfg_x = '{white: white_x_q, thr: thr_q, slope: slope_q};
	assign cfg_y = '{white: white_y_q, thr: thr_q, slope: slope_q};
	assign cfg_z = '{white: white_z_q, thr: thr_q, slope: slope_q};

	// ---------------- pipeline control ----------------
	// One valid bit per stage; the last one is the output register's valid.
	// The pipe moves as a whole; a stalled output freezes every stage.
	logic [PIPE_LAT-1:0] vld_q;
	logic                adv;

	assign adv       = !vld_q[PIPE_LAT-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[PIPE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], in_valid};
		end
	end

	// ---------------- lanes ----------------
	// Each lane: ratio to white (long division, one bit a stage), then
	// cube root (one result bit a stage) or the linear branch.
	logic [F_W-1:0] fx, fy, fz;

	xyzl_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
		.clk(clk), .en(adv), .value(x_value), .cfg(cfg_x), .f(fx)
	);
	xyzl_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
		.clk(clk), .en(adv), .value(y_value), .cfg(cfg_y), .f(fy)
	);
	xyzl_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
		.clk(clk), .en(adv), .value(z_value), .cfg(cfg_z), .f(fz)
	);

	// ---------------- merge ----------------
	// L = 116 fy - 16, a = 500 (fx - fy), b = 200 (fy - fz); round, saturate.
	xyzl_merge u_merge (
		.clk(clk), .en(adv), .fx(fx), .fy(fy), .fz(fz),
		.lightness(lightness), .green_red(green_red), .blue_yellow(blue_yellow)
	);

	// ---------------- checks ----------------
	`XYZL_ASSERT_NXT(a_stall_freezes, !adv, $stable(vld_q))
	`XYZL_ASSERT_IMP(a_l_range, out_valid, lightness <= 16'(LAB_L_MAX))
	`XYZL_ASSERT_IMP(a_a_range, out_valid, (green_red >= 19'(LAB_A_MIN)) && (green_red <= 19'(LAB_A_MAX)))
	`XYZL_ASSERT_IMP(a_b_range, out_valid, (blue_yellow >= 17'(LAB_B_MIN)) && (blue_yellow <= 17'(LAB_B_MAX)))
endmodule
`default_nettype wire

// File: sv/xyzl_lane.sv
// One component lane: ratio to white by long division, then cube root or linear branch.
`timescale 1ns / 1ps
`default_nettype none
module xyzl_lane #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [xyzl_pkg::IN_W-1:0] value,
	input  wire xyzl_pkg::lane_cfg_t       cfg,
	output logic [xyzl_pkg::F_W-1:0]       f
);
	import xyzl_pkg::*;

	logic [WHITE_W-1:0] w_eff;
	logic [DEN_W-1:0]   den_cube;
	logic [DEN_W-1:0]   den_lin;

	// zero white acts as one LSB
	assign w_eff    = (cfg.white == '0) ? WHITE_W'(1) : cfg.white;
	assign den_cube = DEN_W'(w_eff);
	assign den_lin  = DEN_W'(w_eff) * DEN_W'(LIN_DEN);

	// front: products, then branch pick and dividend
	logic [IN_W-1:0]          v_s0;
	logic [THR_W+WHITE_W-1:0] thr_prod_s0;
	logic [SLOPE_W+IN_W-1:0]  slope_prod_s0;

	always_ff @(posedge clk) begin
		if (en) begin
			v_s0          <= value;
			thr_prod_s0   <= (THR_W+WHITE_W)'(cfg.thr) * (THR_W+WHITE_W)'(w_eff);
			slope_prod_s0 <= (SLOPE_W+IN_W)'(cfg.slope) * (SLOPE_W+IN_W)'(value);
		end
	end

	logic             cube_pick;
	logic [NUM_W-1:0] num_lin;

	assign cube_pick = (64'(v_s0) << FRAC_BITS) > 64'(thr_prod_s0);
	assign num_lin   = NUM_W'(slope_prod_s0) + (NUM_W'(w_eff) << 12);

	logic [DEN_W-1:0] dv_rem_s  [0:DIV_W];
	logic [DIV_W-1:0] dv_work_s [0:DIV_W];
	logic             dv_cube_s [0:DIV_W];

	always_ff @(posedge clk) begin
		if (en) begin
			dv_rem_s[0]  <= '0;
			dv_cube_s[0] <= cube_pick;
			dv_work_s[0] <= cube_pick ? {v_s0, {(3*FQ){1'b0}}}
			                          : DIV_W'({num_lin, {FQ{1'b0}}});
		end
	end

	// restoring divider, one quotient bit per stage, quotient shifts into work
	for (genvar i = 1; i <= DIV_W; i++) begin : g_div
		logic [DEN_W:0]   shifted;
		logic [DEN_W-1:0] den;
		logic             ge;
		logic [DEN_W:0]   diff;

		assign den     = dv_cube_s[i-1] ? den_cube : den_lin;
		assign shifted = {dv_rem_s[i-1], dv_work_s[i-1][DIV_W-1]};
		assign ge      = shifted >= {1'b0, den};
		assign diff    = shifted - {1'b0, den};

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_s[i]  <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
				dv_work_s[i] <= {dv_work_s[i-1][DIV_W-2:0], ge};
				dv_cube_s[i] <= dv_cube_s[i-1];
			end
		end
	end

	logic [X_W-1:0]  rt_x_s    [1:ROOT_STEPS];
	logic [Y_W-1:0]  rt_y_s    [1:ROOT_STEPS];
	logic [Y2_W-1:0] rt_y2_s   [1:ROOT_STEPS];
	logic            rt_cube_s [1:ROOT_STEPS];

	// bitwise integer cube root; linear items pass the quotient untouched
	for (genvar j = 1; j <= ROOT_STEPS; j++) begin : g_root
		localparam int SH = 3 * (ROOT_STEPS - j);
		logic [X_W-1:0]  x_in;
		logic [Y_W-1:0]  y_in;
		logic [Y2_W-1:0] y2_in;
		logic            cube_in;
		logic [Y_W-1:0]  y_d;
		logic [Y2_W-1:0] y2_d;
		logic [B_W-1:0]  b;
		logic            take;

		if (j == 1) begin : g_src
			assign x_in    = X_W'(dv_work_s[DIV_W]);
			assign y_in    = '0;
			assign y2_in   = '0;
			assign cube_in = dv_cube_s[DIV_W];
		end else begin : g_chain
			assign x_in    = rt_x_s[j-1];
			assign y_in    = rt_y_s[j-1];
			assign y2_in   = rt_y2_s[j-1];
			assign cube_in = rt_cube_s[j-1];
		end

		assign y_d  = {y_in[Y_W-2:0], 1'b0};
		assign y2_d = {y2_in[Y2_W-3:0], 2'b00};
		assign b    = B_W'(3) * B_W'(y2_d) + B_W'(3) * B_W'(y_d) + B_W'(1);
		assign take = cube_in && ((x_in >> SH) >= X_W'(b));

		always_ff @(posedge clk) begin
			if (en) begin
				rt_x_s[j]    <= take ? x_in - (X_W'(b) << SH) : x_in;
				rt_y_s[j]    <= y_d + Y_W'(take);
				rt_y2_s[j]   <= take ? y2_d + Y2_W'({y_d, 1'b0}) + Y2_W'(1) : y2_d;
				rt_cube_s[j] <= cube_in;
			end
		end
	end

	assign f = rt_cube_s[ROOT_STEPS] ? F_W'(rt_y_s[ROOT_STEPS]) : F_W'(rt_x_s[ROOT_STEPS]);
endmodule
`default_nettype wire

// File: sv/xyzl_merge.sv
// Merge stage: forms L, a, b from the three lane results, rounds and saturates.
`timescale 1ns / 1ps
`default_nettype none
module xyzl_merge (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic [xyzl_pkg::F_W-1:0] fx,
	input  wire logic [xyzl_pkg::F_W-1:0] fy,
	input  wire logic [xyzl_pkg::F_W-1:0] fz,
	output logic [15:0]                   lightness,
	output logic signed [18:0]            green_red,
	output logic signed [16:0]            blue_yellow
);
	import xyzl_pkg::*;

	localparam logic signed [RAW_W-1:0] K_L    = 116;
	localparam logic signed [RAW_W-1:0] K_A    = 500;
	localparam logic signed [RAW_W-1:0] K_B    = 200;
	localparam logic signed [RAW_W-1:0] L_OFS  = 64'sd16 <<< FQ;
	localparam logic signed [RAW_W-1:0] HALF   = 64'sd1 <<< (OUT_SHIFT - 1);

	// round half up (floor after adding half), then clamp
	function automatic logic signed [RAW_W-1:0] rnd_sat(
		input logic signed [RAW_W-1:0] raw,
		input logic signed [RAW_W-1:0] lo,
		input logic signed [RAW_W-1:0] hi
	);
		logic signed [RAW_W-1:0] r;
		r = (raw + HALF) >>> OUT_SHIFT;
		if (r < lo) begin
			r = lo;
		end else if (r > hi) begin
			r = hi;
		end
		return r;
	endfunction

	logic signed [RAW_W-1:0] fx_e, fy_e, fz_e;
	logic signed [RAW_W-1:0] l_raw_s1, a_raw_s1, b_raw_s1;
	logic signed [RAW_W-1:0] l_sat, a_sat, b_sat;

	assign fx_e = RAW_W'(fx);
	assign fy_e = RAW_W'(fy);
	assign fz_e = RAW_W'(fz);

	always_ff @(posedge clk) begin
		if (en) begin
			l_raw_s1 <= fy_e * K_L - L_OFS;
			a_raw_s1 <= (fx_e - fy_e) * K_A;
			b_raw_s1 <= (fy_e - fz_e) * K_B;
		end
	end

	assign l_sat = rnd_sat(l_raw_s1, RAW_W'(LAB_L_MIN), RAW_W'(LAB_L_MAX));
	assign a_sat = rnd_sat(a_raw_s1, RAW_W'(LAB_A_MIN), RAW_W'(LAB_A_MAX));
	assign b_sat = rnd_sat(b_raw_s1, RAW_W'(LAB_B_MIN), RAW_W'(LAB_B_MAX));

	always_ff @(posedge clk) begin
		if (en) begin
			lightness   <= l_sat[15:0];
			green_red   <= a_sat[18:0];
			blue_yellow <= b_sat[16:0];
		end
	end
endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the XYZ to CIELAB converter unit.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import xyzl_pkg::*;

	typedef struct {
		logic [IN_W-1:0] x;
		logic [IN_W-1:0] y;
		logic [IN_W-1:0] z;
	} xyz_beat_t;

	typedef struct {
		logic [15:0]        l;
		logic signed [18:0] a;
		logic signed [16:0] b;
	} lab_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [IN_W-1:0] x_value = '0;
	logic [IN_W-1:0] y_value = '0;
	logic [IN_W-1:0] z_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [15:0] lightness;
	logic signed [18:0] green_red;
	logic signed [16:0] blue_yellow;

	xyz_to_lab_converter_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.x_value(x_value), .y_value(y_value), .z_value(z_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.lightness(lightness), .green_red(green_red), .blue_yellow(blue_yellow)
	);

	// predictor's copy of the registers
	logic [WHITE_W-1:0] wx_m = WHITE_X_RST;
	logic [WHITE_W-1:0] wy_m = WHITE_Y_RST;
	logic [WHITE_W-1:0] wz_m = WHITE_Z_RST;
	logic [THR_W-1:0]   thr_m = THR_RST;
	logic [SLOPE_W-1:0] slope_m = SLOPE_RST;

	xyz_beat_t xyz_queue[$];
	lab_beat_t lab_pending[$];
	int errors = 0;
	bit in_taken = 1'b0;
	bit steady = 1'b0;       // no idling on either side
	bit hold_request = 1'b0; // receiver long hold-off
	int send_gap = 0;
	int recv_gap = 0;
	int stall_cycles = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	// f(v / w) with 28 fraction bits, truncated
	function automatic logic [63:0] lab_f(logic [IN_W-1:0] v, logic [WHITE_W-1:0] wi);
		logic [127:0] w;
		logic [127:0] target;
		logic [127:0] c;
		logic [127:0] num;
		logic [63:0] f;
		w = (wi == 0) ? 128'd1 : 128'(wi);
		f = '0;
		if ((128'(v) << 16) > 128'(thr_m) * w) begin
			// largest f with f^3 * w <= v * 2^84
			target = 128'(v) << 84;
			for (int bt = 34; bt >= 0; bt--) begin
				c = 128'(f) | (128'd1 << bt);
				if (c * c * c * w <= target)
					f = c[63:0];
			end
		end else begin
			num = (128'(slope_m) * 128'(v) + 128'd4096 * w) << FQ;
			num = num / (128'(LIN_DEN) * w);
			f = num[63:0];
		end
		return f;
	endfunction

	// round half up to 8 fraction bits: floor((x + half) / 2^20)
	function automatic longint to_out(longint x);
		return (x + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
	endfunction

	function automatic lab_beat_t lab_expected(xyz_beat_t px);
		longint fx, fy, fz, l, a, b;
		lab_beat_t r;
		fx = longint'(lab_f(px.x, wx_m));
		fy = longint'(lab_f(px.y, wy_m));
		fz = longint'(lab_f(px.z, wz_m));
		l = to_out(116 * fy - (64'sd16 <<< FQ));
		a = to_out(500 * (fx - fy));
		b = to_out(200 * (fy - fz));
		l = (l < LAB_L_MIN) ? longint'(LAB_L_MIN) : (l > LAB_L_MAX ? longint'(LAB_L_MAX) : l);
		a = (a < LAB_A_MIN) ? longint'(LAB_A_MIN) : (a > LAB_A_MAX ? longint'(LAB_A_MAX) : a);
		b = (b < LAB_B_MIN) ? longint'(LAB_B_MIN) : (b > LAB_B_MAX ? longint'(LAB_B_MAX) : b);
		r.l = l[15:0];
		r.a = a[18:0];
		r.b = b[16:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int p;
		p = $urandom_range(99);
		if (steady || p < 65) return 0;
		if (p < 95) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// one component value, steered toward interesting regions
	function automatic logic [IN_W-1:0] pick_value(logic [WHITE_W-1:0] w);
		int p;
		longint edge_v;
		p = $urandom_range(99);
		edge_v = (longint'(thr_m) * longint'(w == 0 ? 1 : w)) >>> 16;
		if (p < 35) return IN_W'($urandom_range(131071));
		if (p < 55) return IN_W'($urandom_range(2000));
		if (p < 75) return IN_W'(longint'(w) + $urandom_range(4000) - 2000);
		if (p < 95) return IN_W'(edge_v + $urandom_range(2) - 1);
		return (p & 1) ? 17'h1FFFF : 17'h0;
	endfunction

	task automatic push_xyz(logic [IN_W-1:0] x, logic [IN_W-1:0] y, logic [IN_W-1:0] z);
		xyz_beat_t b;
		b.x = x;
		b.y = y;
		b.z = z;
		xyz_queue.push_back(b);
	endtask

	task automatic push_random(int n);
		for (int i = 0; i < n; i++)
			push_xyz(pick_value(wx_m), pick_value(wy_m), pick_value(wz_m));
	endtask

	// config write; model copy takes the masked value, indexes above four do nothing
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_WHITE_X: wx_m = val[WHITE_W-1:0];
			REG_WHITE_Y: wy_m = val[WHITE_W-1:0];
			REG_WHITE_Z: wz_m = val[WHITE_W-1:0];
			REG_THR:     thr_m = val[THR_W-1:0];
			REG_SLOPE:   slope_m = val[SLOPE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_all(logic [CFG_W-1:0] wx, logic [CFG_W-1:0] wy, logic [CFG_W-1:0] wz,
			logic [CFG_W-1:0] thr, logic [CFG_W-1:0] slope);
		write_reg(REG_WHITE_X, wx);
		write_reg(REG_WHITE_Y, wy);
		write_reg(REG_WHITE_Z, wz);
		write_reg(REG_THR, thr);
		write_reg(REG_SLOPE, slope);
		// unused index with junk data must be ignored
		write_reg(IDX_W'($urandom_range(7, 5)), CFG_W'($urandom));
	endtask

	// sender waits until the pipe is empty, then lets it settle
	task automatic wait_drained();
		while (xyz_queue.size() != 0 || in_valid || lab_pending.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 10) @(negedge clk);
	endtask

	// input side: accept, predict; output side: compare
	always @(posedge clk) begin
		lab_beat_t want;
		xyz_beat_t got_in;
		if (in_valid && in_ready) begin
			got_in.x = x_value;
			got_in.y = y_value;
			got_in.z = z_value;
			lab_pending.push_back(lab_expected(got_in));
			in_taken = 1'b1;
		end
		if (out_valid && out_ready) begin
			if (lab_pending.size() == 0) begin
				report_mismatch("unexpected beat, lightness", lightness, -1);
			end else begin
				want = lab_pending.pop_front();
				if (lightness !== want.l) report_mismatch("lightness", lightness, want.l);
				if (green_red !== want.a) report_mismatch("green_red", green_red, want.a);
				if (blue_yellow !== want.b)
					report_mismatch("blue_yellow", blue_yellow, want.b);
			end
		end
	end

	// driver: payload held until the beat is taken
	always @(negedge clk) begin
		xyz_beat_t nxt;
		logic nv;
		if (arst_n && (!in_valid || in_taken)) begin
			in_taken = 1'b0;
			nv = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
			end else if (xyz_queue.size() != 0) begin
				nxt = xyz_queue.pop_front();
				x_value <= nxt.x;
				y_value <= nxt.y;
				z_value <= nxt.z;
				nv = 1'b1;
				send_gap = pick_gap();
			end
			in_valid <= nv;
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_request) begin
				hold_request = 1'b0;
				stall_cycles = 400;
			end
			if (stall_cycles > 0) begin
				stall_cycles--;
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				recv_gap = pick_gap();
			end
		end
	end

	// watchdog: cycles with work pending but no beat on either side
	int idle_count = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)
				|| (lab_pending.size() == 0 && !in_valid)) begin
			idle_count <= 0;
		end else if (idle_count >= 5000) begin
			$display("xyz_to_lab_converter_unit test failed");
			$finish;
		end else begin
			idle_count <= idle_count + 1;
		end
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed, reset defaults
		push_xyz(17'd0, 17'd0, 17'd0);
		push_xyz(17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
		push_xyz(WHITE_X_RST, WHITE_Y_RST, WHITE_Z_RST);
		push_xyz(17'h1FFFF, 17'd0, 17'h1FFFF);
		push_xyz(17'd0, 17'h1FFFF, 17'd0);
		push_xyz(17'h1FFFF, 17'd0, 17'd0);
		push_xyz(17'd0, 17'd0, 17'h1FFFF);
		// Y exactly at the threshold, one above, one below
		push_xyz(17'd562, 17'd580, 17'd632);
		push_xyz(17'd563, 17'd581, 17'd633);
		push_xyz(17'd561, 17'd579, 17'd631);
		push_xyz(17'd1, 17'd1, 17'd1);
		push_xyz(17'h0AAAA, 17'h15555, 17'h0F0F0);
		push_xyz(17'h15555, 17'h0AAAA, 17'h10F0F);
		wait_drained();

		// zero whites count as one LSB; the highest threshold then still sends every nonzero input to the cube root
		set_all(18'd0, 18'd0, 18'd0, 18'd65535, 18'd262143);
		push_xyz(17'd0, 17'd1, 17'd2);
		push_xyz(17'h1FFFF, 17'h1FFFF, 17'd0);
		push_random(150);
		wait_drained();

		// threshold zero: all nonzero inputs take the cube root
		set_all(18'd1, 18'd131071, 18'd1, 18'd0, 18'd0);
		push_xyz(17'd0, 17'd0, 17'd0);
		push_xyz(17'd1, 17'd1, 17'd1);
		hold_request = 1'b1;
		push_random(200);
		wait_drained();

		// largest whites, slope zero
		set_all(18'd131071, 18'd131071, 18'd131071, 18'd65535, 18'd0);
		push_xyz(17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
		steady = 1'b1;
		push_random(200);
		wait_drained();
		steady = 1'b0;

		// bits above the register width must be dropped
		set_all(18'h3FFFF, 18'h20001, 18'h2FFFF, 18'h3FFFF, 18'h3FFFF);
		push_random(150);
		wait_drained();

		set_all(CFG_W'(WHITE_X_RST), CFG_W'(WHITE_Y_RST), CFG_W'(WHITE_Z_RST),
			CFG_W'(THR_RST), CFG_W'(SLOPE_RST));
		push_random(300);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			set_all(CFG_W'($urandom_range(131071, 1)), CFG_W'($urandom_range(131071, 1)),
				CFG_W'($urandom_range(131071, 1)), CFG_W'($urandom_range(65535)),
				CFG_W'($urandom_range(262143)));
			push_random(150);
			wait_drained();
		end

		if (errors == 0) begin
			$display("xyz_to_lab_converter_unit test passed");
		end else begin
			$display("xyz_to_lab_converter_unit test failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

// File: files.f
+incdir+sv
sv/xyzl_pkg.sv
sv/xyzl_lane.sv
sv/xyzl_merge.sv
sv/xyz_to_lab_converter_unit.sv
tb/sv/testbench.sv
